FILE: hw/rtl/tvs_pkg.sv
// Shared types and constants of the trilinear volume sampler.
package tvs_pkg;

	localparam int SIZE_X_DEF    = 256;
	localparam int SIZE_Y_DEF    = 256;
	localparam int SIZE_Z_DEF    = 128;
	localparam int FRAC_BITS_DEF = 8;

	localparam int VAL_W   = 12;
	localparam int POS_W   = 16;
	localparam int OUT_W   = 21;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 12;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_ISO_LEVEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALVE_Z   = 1'b1;

	localparam logic [VAL_W-1:0] ISO_LEVEL_RST = 12'd1407;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} tvs_op_t;

	typedef struct packed {
		tvs_op_t          op;
		logic [POS_W-1:0] cx;
		logic [POS_W-1:0] cy;
		logic [POS_W-1:0] cz;
		logic [2:0]       sat;
		logic [POS_W-1:0] fx;
		logic [POS_W-1:0] fy;
		logic [POS_W-1:0] fz;
		logic [VAL_W-1:0] wval;
	} tvs_item_t;

endpackage

FILE: hw/rtl/tvs_if.sv
// Handshake channels of the trilinear volume sampler.
interface tvs_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  voxel_x;
	logic [7:0]  voxel_y;
	logic [6:0]  voxel_z;
	logic [11:0] voxel_value;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [15:0] pos_z;
	modport source (output valid, cmd, voxel_x, voxel_y, voxel_z, voxel_value,
		pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, cmd, voxel_x, voxel_y, voxel_z, voxel_value,
		pos_x, pos_y, pos_z, output ready);
endinterface

interface tvs_out_if;
	logic               valid;
	logic               ready;
	logic signed [20:0] field_value;
	modport source (output valid, field_value, input ready);
	modport sink (input valid, field_value, output ready);
endinterface

interface tvs_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [11:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tvs_ram.sv
// Generic single-port RAM with registered read.
module tvs_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                                         clk,
	input  logic                                         en,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                             wdata,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end
endmodule

FILE: hw/rtl/tvs_fifo.sv
// Short queue between front and back.
module tvs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [AW:0]      cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = buf_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			if (pop)  rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wptr_q] <= wdata;
	end
endmodule

FILE: hw/rtl/tvs_front.sv
// Front end: accepts beats, classifies them and splits positions into corners.
module tvs_front import tvs_pkg::*; #(
	parameter int SIZE_X    = SIZE_X_DEF,
	parameter int SIZE_Y    = SIZE_Y_DEF,
	parameter int SIZE_Z    = SIZE_Z_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tvs_in_if.sink     in_ch,
	input  logic       halve_z,
	output tvs_item_t  item,
	output logic       item_valid,
	input  logic       item_ready
);
	localparam logic [POS_W-1:0] LAST_X = POS_W'(SIZE_X - 1);
	localparam logic [POS_W-1:0] LAST_Y = POS_W'(SIZE_Y - 1);
	localparam logic [POS_W-1:0] LAST_Z = POS_W'(SIZE_Z - 1);
	localparam logic [POS_W-1:0] FMASK  = POS_W'((1 << FRAC_BITS) - 1);

	tvs_item_t        nxt, item_s1;
	logic             keep, v_s1;
	logic [POS_W-1:0] pz, ipx, ipy, ipz;

	always_comb begin
		nxt      = '0;
		keep     = 1'b0;
		pz       = halve_z ? {1'b0, in_ch.pos_z[POS_W-1:1]} : in_ch.pos_z;
		ipx      = in_ch.pos_x >> FRAC_BITS;
		ipy      = in_ch.pos_y >> FRAC_BITS;
		ipz      = pz >> FRAC_BITS;
		nxt.op   = tvs_op_t'(in_ch.cmd);
		unique case (tvs_op_t'(in_ch.cmd))
			OP_WRITE: begin
				nxt.cx   = POS_W'(in_ch.voxel_x);
				nxt.cy   = POS_W'(in_ch.voxel_y);
				nxt.cz   = POS_W'(in_ch.voxel_z);
				nxt.wval = in_ch.voxel_value;
				keep     = (POS_W'(in_ch.voxel_x) < POS_W'(SIZE_X)) &&
					(POS_W'(in_ch.voxel_y) < POS_W'(SIZE_Y)) &&
					(POS_W'(in_ch.voxel_z) < POS_W'(SIZE_Z));
			end
			OP_SAMPLE: begin
				nxt.sat[2] = (ipx >= LAST_X);
				nxt.sat[1] = (ipy >= LAST_Y);
				nxt.sat[0] = (ipz >= LAST_Z);
				nxt.cx = nxt.sat[2] ? LAST_X : ipx;
				nxt.cy = nxt.sat[1] ? LAST_Y : ipy;
				nxt.cz = nxt.sat[0] ? LAST_Z : ipz;
				nxt.fx = nxt.sat[2] ? '0 : (in_ch.pos_x & FMASK);
				nxt.fy = nxt.sat[1] ? '0 : (in_ch.pos_y & FMASK);
				nxt.fz = nxt.sat[0] ? '0 : (pz & FMASK);
				keep   = 1'b1;
			end
		endcase
	end

	assign in_ch.ready = !v_s1 || item_ready;
	assign item        = item_s1;
	assign item_valid  = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) item_s1 <= nxt;
	end
endmodule

FILE: hw/rtl/tvs_back.sv
// Back end: eight-bank voxel store and the pipelined trilinear blend.
module tvs_back import tvs_pkg::*; #(
	parameter int SIZE_X    = SIZE_X_DEF,
	parameter int SIZE_Y    = SIZE_Y_DEF,
	parameter int SIZE_Z    = SIZE_Z_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tvs_item_t        item,
	input  logic             item_valid,
	output logic             pop,
	input  logic [VAL_W-1:0] iso_level,
	tvs_out_if.source        out_ch
);
	localparam int HX    = (SIZE_X + 1) / 2;
	localparam int HY    = (SIZE_Y + 1) / 2;
	localparam int HZ    = (SIZE_Z + 1) / 2;
	localparam int BDEP  = HX * HY * HZ;
	localparam int BAW   = (BDEP > 1) ? $clog2(BDEP) : 1;
	localparam int WW    = FRAC_BITS + 1;
	localparam int ZW    = VAL_W + FRAC_BITS + 1;
	localparam int YW    = VAL_W + 2 * FRAC_BITS + 1;
	localparam int SW    = VAL_W + 3 * FRAC_BITS + 1;
	localparam logic [WW-1:0] ONE = WW'(1 << FRAC_BITS);
	localparam logic [SW:0]   HALF = (SW+1)'(1) << (2 * FRAC_BITS - 1);
	localparam logic signed [63:0] OMAX = 64'sd1048575;
	localparam logic signed [63:0] OMIN = -64'sd1048576;

	function automatic logic [BAW-1:0] baddr(input logic [POS_W:0] hx,
		input logic [POS_W:0] hy, input logic [POS_W:0] hz);
		logic [31:0] a;
		a = (32'(hx) * 32'(HY) + 32'(hy)) * 32'(HZ) + 32'(hz);
		return a[BAW-1:0];
	endfunction

	function automatic logic [POS_W:0] half_for(input logic [POS_W-1:0] c, input logic p);
		logic [POS_W:0] e;
		e = (c[0] == p) ? {1'b0, c} : ({1'b0, c} + 1'b1);
		return e >> 1;
	endfunction

	logic             adv, is_wr;
	logic [2:0]       wbank;
	logic [BAW-1:0]   waddr;
	logic [BAW-1:0]   addr [8];
	logic             en   [8];
	logic [VAL_W-1:0] rd   [8];

	logic             v_s2, v_s3, v_s4, v_s5, out_v_q;
	logic [2:0]       par_s2, sat_s2;
	logic [WW-1:0]    wx_s2 [2], wy_s2 [2], wz_s2 [2];
	logic [WW-1:0]    wx_s3 [2], wy_s3 [2], wx_s4 [2];
	logic [ZW-1:0]    z_s3 [2][2];
	logic [YW-1:0]    y_s4 [2];
	logic [SW-1:0]    sum_s5;
	logic signed [OUT_W-1:0] field_q;

	logic [VAL_W-1:0] cv   [2][2][2];
	logic [ZW-1:0]    z_n  [2][2];
	logic [YW-1:0]    y_n  [2];
	logic [SW-1:0]    s_n;
	logic [SW:0]      rnd;
	logic signed [63:0] res;

	assign adv   = !out_v_q || out_ch.ready;
	assign pop   = adv && item_valid;
	assign is_wr = (item.op == OP_WRITE);
	assign wbank = {item.cx[0], item.cy[0], item.cz[0]};
	assign waddr = baddr({2'b0, item.cx[POS_W-1:1]}, {2'b0, item.cy[POS_W-1:1]},
		{2'b0, item.cz[POS_W-1:1]});

	for (genvar k = 0; k < 8; k++) begin : g_bank
		localparam logic [2:0] KB = 3'(k);
		assign addr[k] = is_wr ? waddr :
			baddr(half_for(item.cx, KB[2]), half_for(item.cy, KB[1]), half_for(item.cz, KB[0]));
		assign en[k] = pop && (!is_wr || wbank == KB);
		tvs_ram #(.WIDTH(VAL_W), .DEPTH(BDEP)) u_ram (
			.clk   (clk),
			.en    (en[k]),
			.we    (is_wr),
			.addr  (addr[k]),
			.wdata (item.wval),
			.rdata (rd[k])
		);
	end

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			for (int b = 0; b < 2; b++) begin
				for (int c = 0; c < 2; c++) begin
					cv[a][b][c] = rd[{par_s2[2] ^ (1'(a) & ~sat_s2[2]),
						par_s2[1] ^ (1'(b) & ~sat_s2[1]),
						par_s2[0] ^ (1'(c) & ~sat_s2[0])}];
				end
				z_n[a][b] = ZW'(cv[a][b][0]) * ZW'(wz_s2[0]) + ZW'(cv[a][b][1]) * ZW'(wz_s2[1]);
			end
			y_n[a] = YW'(z_s3[a][0]) * YW'(wy_s3[0]) + YW'(z_s3[a][1]) * YW'(wy_s3[1]);
		end
		s_n = SW'(y_s4[0]) * SW'(wx_s4[0]) + SW'(y_s4[1]) * SW'(wx_s4[1]);
		rnd = {1'b0, sum_s5} + HALF;
		res = $signed(64'(iso_level) << FRAC_BITS) - $signed(64'(rnd >> (2 * FRAC_BITS)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s2    <= pop && !is_wr;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			out_v_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			par_s2   <= {item.cx[0], item.cy[0], item.cz[0]};
			sat_s2   <= item.sat;
			wx_s2[0] <= ONE - WW'(item.fx);
			wx_s2[1] <= WW'(item.fx);
			wy_s2[0] <= ONE - WW'(item.fy);
			wy_s2[1] <= WW'(item.fy);
			wz_s2[0] <= ONE - WW'(item.fz);
			wz_s2[1] <= WW'(item.fz);
			z_s3     <= z_n;
			wx_s3    <= wx_s2;
			wy_s3    <= wy_s2;
			y_s4     <= y_n;
			wx_s4    <= wx_s3;
			sum_s5   <= s_n;
			if (res > OMAX) field_q <= OUT_W'(OMAX);
			else if (res < OMIN) field_q <= OUT_W'(OMIN);
			else field_q <= OUT_W'(res);
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.field_value = field_q;
endmodule

FILE: hw/rtl/trilinear_volume_sampler_top.sv
// Top level of the trilinear volume sampler.
// Eight voxel banks serve all corners; samples pass stages s2 to s5 to the output register.
// Throughput: one beat per cycle, voxel write or sample, when the output is not stalled.
// Writes produce no result; the blend pipeline stalls as one on output back-pressure.
// Reset clears control state, iso_level to 1407 and halve_z to 1.
// The voxel store is not cleared: unwritten voxels read as undefined.
module trilinear_volume_sampler_top import tvs_pkg::*; #(
	parameter int SIZE_X    = SIZE_X_DEF,
	parameter int SIZE_Y    = SIZE_Y_DEF,
	parameter int SIZE_Z    = SIZE_Z_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tvs_cfg_if.sink    cfg,
	tvs_in_if.sink     in_ch,
	tvs_out_if.source  out_ch
);
	localparam int ITEM_W = $bits(tvs_item_t);

	logic [VAL_W-1:0] iso_level_q;
	logic             halve_z_q;
	tvs_item_t        f_item, q_item;
	logic             f_valid, q_full, q_empty, push, pop;
	logic [ITEM_W-1:0] q_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_level_q <= ISO_LEVEL_RST;
			halve_z_q   <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ISO_LEVEL: iso_level_q <= cfg.data;
				CFG_HALVE_Z:   halve_z_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	tvs_front #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z), .FRAC_BITS(FRAC_BITS))
	u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.halve_z    (halve_z_q),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (!q_full)
	);

	assign push = f_valid && !q_full;

	tvs_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_item),
		.full   (q_full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign q_item = tvs_item_t'(q_rdata);

	tvs_back #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z), .FRAC_BITS(FRAC_BITS))
	u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_item),
		.item_valid (!q_empty),
		.pop        (pop),
		.iso_level  (iso_level_q),
		.out_ch     (out_ch)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_empty)
		else $error("queue popped while empty");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("queue pushed while full");
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && q_full) |=> f_valid)
		else $error("front item lost while queue full");
endmodule
